>>> hdl/crowding_nearest_replace_unit_macros.svh
// Assertion macros used by the crowding replacement unit checker.
`ifndef CROWDING_NEAREST_REPLACE_UNIT_MACROS_SVH
`define CROWDING_NEAREST_REPLACE_UNIT_MACROS_SVH

// Next-cycle implication, suspended while reset is low
`define CNR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Holds on the edge after reset is applied
`define CNR_ASSERT_AFTER_RESET(label, clk, rstn, cons, msg) \
    label: assert property (@(posedge clk) !rstn |=> (cons)) else $error(msg);

`endif

>>> hdl/cnr_pkg.sv
// Shared types, constants and helper functions of the crowding replacement unit.
package cnr_pkg;

    // default sizes of the tables
    localparam int MAX_POPULATION_DEF = 32;
    localparam int MAX_DIMENSION_DEF  = 64;

    // field widths
    localparam int COORD_BITS  = 16;
    localparam int SLOT_W      = 5;
    localparam int INDEX_W     = 6;
    localparam int FIT_W       = 32;
    localparam int POP_CFG_W   = 6;
    localparam int DIM_CFG_W   = 7;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 1;

    // squared difference of two saturated coordinates
    localparam int SQ_W = 2 * COORD_BITS + 2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_POPULATION_IN_USE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIMENSION_IN_USE  = 1'b1;

    localparam logic [POP_CFG_W-1:0] POP_CFG_RESET = 6'd30;
    localparam logic [DIM_CFG_W-1:0] DIM_CFG_RESET = 7'd10;

    // beat kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_CHILD = 1'b1;

    // coordinate range is +-100.0 in Q8.8
    localparam logic signed [COORD_BITS-1:0] COORD_CEIL  = 16'sd25600;
    localparam logic signed [COORD_BITS-1:0] COORD_FLOOR = -16'sd25600;

    localparam logic signed [FIT_W-1:0] BEST_RESET = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic                     kind;
        logic [SLOT_W-1:0]        slot;
        logic [INDEX_W-1:0]       coord_index;
        logic signed [COORD_BITS-1:0] coord_value;
        logic signed [FIT_W-1:0]  fitness_value;
        logic                     last_coord;
    } in_beat_t;

    typedef struct packed {
        logic [SLOT_W-1:0]       nearest_slot;
        logic                    was_replaced;
        logic                    best_improved;
        logic signed [FIT_W-1:0] best_fitness_out;
    } out_beat_t;

    // controller to datapath
    typedef struct packed {
        logic accept;      // input beat taken this cycle
        logic srch_start;  // clear the running minimum
        logic srch_issue;  // read one coordinate pair
        logic srch_first;  // pair is coordinate zero of its slot
        logic srch_end;    // pair is the last coordinate of its slot
        logic fit_cmp;     // fitness of the nearest slot is on the read port
        logic copy_issue;  // read one child coordinate for copy-back
        logic out_child;   // load the child result into the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic fit_better;
        logic out_free;
    } sts_t;

    // address bits for a table of n entries, at least one
    function automatic int idx_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // clamp a Q8.8 coordinate to +-100.0
    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [COORD_BITS-1:0] v
    );
        logic signed [COORD_BITS-1:0] r;
        r = v;
        if (v > COORD_CEIL) begin
            r = COORD_CEIL;
        end else if (v < COORD_FLOOR) begin
            r = COORD_FLOOR;
        end
        return r;
    endfunction

endpackage

>>> hdl/cnr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cnr_ram #(
    parameter int WIDTH = cnr_pkg::COORD_BITS,
    parameter int DEPTH = cnr_pkg::MAX_DIMENSION_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/cnr_ctrl.sv
// Controller: configuration registers, handshake, sequencing FSM and walk counters.
module cnr_ctrl #(
    parameter int MAX_POPULATION = cnr_pkg::MAX_POPULATION_DEF,
    parameter int MAX_DIMENSION  = cnr_pkg::MAX_DIMENSION_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         cfg_we,
    input  logic [cnr_pkg::CFG_INDEX_W-1:0]              cfg_index,
    input  logic [cnr_pkg::CFG_DATA_W-1:0]               cfg_data,
    input  logic                                         s_valid,
    input  logic                                         s_kind,
    input  logic                                         s_last,
    output logic                                         s_ready,
    input  cnr_pkg::sts_t                                sts,
    output cnr_pkg::cmd_t                                cmd,
    output logic [cnr_pkg::idx_bits(MAX_POPULATION)-1:0] rd_slot,
    output logic [cnr_pkg::idx_bits(MAX_DIMENSION)-1:0]  rd_coord
);

    localparam int PA = cnr_pkg::idx_bits(MAX_POPULATION);
    localparam int DA = cnr_pkg::idx_bits(MAX_DIMENSION);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_SEARCH  = 7'b0000010,
        ST_DRAIN   = 7'b0000100,
        ST_FIT_RD  = 7'b0001000,
        ST_FIT_CMP = 7'b0010000,
        ST_COPY    = 7'b0100000,
        ST_FINISH  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [cnr_pkg::POP_CFG_W-1:0] pop_cfg_reg;
    logic [cnr_pkg::DIM_CFG_W-1:0] dim_cfg_reg;
    logic [PA-1:0] slot_cnt_reg, slot_cnt_next;
    logic [DA-1:0] coord_cnt_reg, coord_cnt_next;
    logic [PA-1:0] pop_last;
    logic [DA-1:0] dim_last;
    logic          ready_int;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pop_cfg_reg <= cnr_pkg::POP_CFG_RESET;
            dim_cfg_reg <= cnr_pkg::DIM_CFG_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                cnr_pkg::CFG_POPULATION_IN_USE: begin
                    pop_cfg_reg <= cfg_data[cnr_pkg::POP_CFG_W-1:0];
                end
                cnr_pkg::CFG_DIMENSION_IN_USE: begin
                    dim_cfg_reg <= cfg_data[cnr_pkg::DIM_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // last slot and last coordinate of the walk, clamped to the table sizes
    always_comb begin
        if (pop_cfg_reg == '0) begin
            pop_last = '0;
        end else if (int'(pop_cfg_reg) > MAX_POPULATION) begin
            pop_last = PA'(MAX_POPULATION - 1);
        end else begin
            pop_last = PA'(int'(pop_cfg_reg) - 1);
        end

        if (dim_cfg_reg == '0) begin
            dim_last = '0;
        end else if (int'(dim_cfg_reg) > MAX_DIMENSION) begin
            dim_last = DA'(MAX_DIMENSION - 1);
        end else begin
            dim_last = DA'(int'(dim_cfg_reg) - 1);
        end
    end

    // sequencing
    always_comb begin
        state_next     = state_reg;
        slot_cnt_next  = slot_cnt_reg;
        coord_cnt_next = coord_cnt_reg;
        cmd            = '0;
        ready_int      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                // a final load beat needs the output register free
                ready_int = sts.out_free || !s_last || (s_kind == cnr_pkg::KIND_CHILD);
                slot_cnt_next  = '0;
                coord_cnt_next = '0;
                cmd.accept     = s_valid && ready_int;
                if (cmd.accept && (s_kind == cnr_pkg::KIND_CHILD) && s_last) begin
                    cmd.srch_start = 1'b1;
                    state_next     = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                cmd.srch_issue = 1'b1;
                cmd.srch_first = (coord_cnt_reg == '0);
                cmd.srch_end   = (coord_cnt_reg == dim_last);
                if (coord_cnt_reg == dim_last) begin
                    coord_cnt_next = '0;
                    if (slot_cnt_reg == pop_last) begin
                        state_next = ST_DRAIN;
                    end else begin
                        slot_cnt_next = slot_cnt_reg + PA'(1);
                    end
                end else begin
                    coord_cnt_next = coord_cnt_reg + DA'(1);
                end
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = ST_FIT_RD;
                end
            end
            ST_FIT_RD: begin
                state_next = ST_FIT_CMP;
            end
            ST_FIT_CMP: begin
                cmd.fit_cmp    = 1'b1;
                coord_cnt_next = '0;
                state_next     = sts.fit_better ? ST_COPY : ST_FINISH;
            end
            ST_COPY: begin
                cmd.copy_issue = 1'b1;
                if (coord_cnt_reg == dim_last) begin
                    state_next = ST_FINISH;
                end else begin
                    coord_cnt_next = coord_cnt_reg + DA'(1);
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.out_child = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            slot_cnt_reg  <= '0;
            coord_cnt_reg <= '0;
        end else begin
            state_reg     <= state_next;
            slot_cnt_reg  <= slot_cnt_next;
            coord_cnt_reg <= coord_cnt_next;
        end
    end

    assign s_ready  = ready_int;
    assign rd_slot  = slot_cnt_reg;
    assign rd_coord = coord_cnt_reg;

endmodule

>>> hdl/cnr_dpath.sv
// Datapath: population and child RAMs, distance pipeline, minimum search, best and output.
module cnr_dpath #(
    parameter int MAX_POPULATION = cnr_pkg::MAX_POPULATION_DEF,
    parameter int MAX_DIMENSION  = cnr_pkg::MAX_DIMENSION_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  cnr_pkg::cmd_t                                cmd,
    input  cnr_pkg::in_beat_t                            s_data,
    input  logic [cnr_pkg::idx_bits(MAX_POPULATION)-1:0] rd_slot,
    input  logic [cnr_pkg::idx_bits(MAX_DIMENSION)-1:0]  rd_coord,
    output cnr_pkg::sts_t                                sts,
    output logic                                         m_valid,
    input  logic                                         m_ready,
    output cnr_pkg::out_beat_t                           m_data
);

    localparam int PA     = cnr_pkg::idx_bits(MAX_POPULATION);
    localparam int DA     = cnr_pkg::idx_bits(MAX_DIMENSION);
    localparam int CW     = cnr_pkg::COORD_BITS;
    localparam int FW     = cnr_pkg::FIT_W;
    localparam int SW     = cnr_pkg::SLOT_W;
    localparam int SQW    = cnr_pkg::SQ_W;
    localparam int DIST_W = SQW + DA;

    // input beat decode
    logic                  is_load;
    logic                  is_child;
    logic                  slot_ok;
    logic                  idx_ok;
    logic [PA-1:0]         slot_a;
    logic [DA-1:0]         idx_a;
    logic signed [CW-1:0]  coord_sat;

    assign is_load   = cmd.accept && (s_data.kind == cnr_pkg::KIND_LOAD);
    assign is_child  = cmd.accept && (s_data.kind == cnr_pkg::KIND_CHILD);
    assign slot_ok   = int'(s_data.slot) < MAX_POPULATION;
    assign idx_ok    = int'(s_data.coord_index) < MAX_DIMENSION;
    assign slot_a    = PA'(32'(s_data.slot));
    assign idx_a     = DA'(32'(s_data.coord_index));
    assign coord_sat = cnr_pkg::sat_coord(s_data.coord_value);

    // storage
    logic [PA+DA-1:0] pop_waddr;
    logic [CW-1:0]    pop_wdata;
    logic             pop_we;
    logic [CW-1:0]    pop_rdata;
    logic [CW-1:0]    child_rdata;
    logic             fit_we;
    logic [PA-1:0]    fit_waddr;
    logic [FW-1:0]    fit_wdata;
    logic [FW-1:0]    fit_rdata;

    logic                  copy_v1_reg;
    logic [DA-1:0]         copy_coord1_reg;
    logic [PA-1:0]         nearest_reg, nearest_next;
    logic signed [FW-1:0]  child_fit_reg;
    logic                  fit_better;

    // population coordinates: load beats, or copy-back of a winning child
    assign pop_we    = (is_load && slot_ok && idx_ok) || copy_v1_reg;
    assign pop_waddr = copy_v1_reg ? {nearest_reg, copy_coord1_reg} : {slot_a, idx_a};
    assign pop_wdata = copy_v1_reg ? child_rdata : coord_sat;

    cnr_ram #(
        .WIDTH (CW),
        .DEPTH (2 ** (PA + DA))
    ) u_pop_ram (
        .aclk  (aclk),
        .we    (pop_we),
        .waddr (pop_waddr),
        .wdata (pop_wdata),
        .raddr ({rd_slot, rd_coord}),
        .rdata (pop_rdata)
    );

    cnr_ram #(
        .WIDTH (CW),
        .DEPTH (2 ** DA)
    ) u_child_ram (
        .aclk  (aclk),
        .we    (is_child && idx_ok),
        .waddr (idx_a),
        .wdata (coord_sat),
        .raddr (rd_coord),
        .rdata (child_rdata)
    );

    // fitness table: final load beat, or the replacing child
    assign fit_better = child_fit_reg < $signed(fit_rdata);
    assign fit_we     = (is_load && s_data.last_coord && slot_ok) ||
                        (cmd.fit_cmp && fit_better);
    assign fit_waddr  = cmd.fit_cmp ? nearest_reg : slot_a;
    assign fit_wdata  = cmd.fit_cmp ? child_fit_reg : s_data.fitness_value;

    cnr_ram #(
        .WIDTH (FW),
        .DEPTH (MAX_POPULATION)
    ) u_fit_ram (
        .aclk  (aclk),
        .we    (fit_we),
        .waddr (fit_waddr),
        .wdata (fit_wdata),
        .raddr (nearest_reg),
        .rdata (fit_rdata)
    );

    // distance pipeline: RAM read, square, accumulate, compare
    logic                  s1_v_reg, s1_first_reg, s1_end_reg;
    logic [PA-1:0]         s1_slot_reg;
    logic                  s2_v_reg, s2_first_reg, s2_end_reg;
    logic [PA-1:0]         s2_slot_reg;
    logic [SQW-1:0]        sq2_reg;
    logic [DIST_W-1:0]     acc_reg, acc_sum;
    logic                  dv3_reg;
    logic [DIST_W-1:0]     dist3_reg;
    logic [PA-1:0]         slot3_reg;
    logic [DIST_W-1:0]     min_reg, min_next;
    logic                  have_reg, have_next;
    logic signed [CW:0]    diff;
    logic signed [SQW-1:0] prod;
    logic                  take_new;

    assign diff    = $signed({child_rdata[CW-1], child_rdata}) -
                     $signed({pop_rdata[CW-1], pop_rdata});
    assign prod    = diff * diff;
    assign acc_sum = (s2_first_reg ? '0 : acc_reg) + DIST_W'(sq2_reg);

    // first slot wins ties: only a strictly smaller distance takes over
    assign take_new = dv3_reg && (!have_reg || (dist3_reg < min_reg));

    always_comb begin
        have_next    = have_reg;
        min_next     = min_reg;
        nearest_next = nearest_reg;
        if (cmd.srch_start) begin
            have_next = 1'b0;
        end else if (take_new) begin
            have_next    = 1'b1;
            min_next     = dist3_reg;
            nearest_next = slot3_reg;
        end
    end

    // best fitness and result
    logic signed [FW-1:0] best_reg, best_next;
    logic                 repl_reg, impr_reg;
    logic                 m_valid_reg, m_valid_next;
    cnr_pkg::out_beat_t   m_data_reg, m_data_next;
    logic                 load_impr;
    logic                 child_impr;
    logic                 out_free;

    assign out_free   = !m_valid_reg || m_ready;
    assign load_impr  = s_data.fitness_value < best_reg;
    assign child_impr = fit_better && (child_fit_reg < best_reg);

    always_comb begin
        best_next    = best_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (is_load && s_data.last_coord) begin
            if (load_impr) begin
                best_next = s_data.fitness_value;
            end
            m_valid_next                 = 1'b1;
            m_data_next.nearest_slot     = s_data.slot;
            m_data_next.was_replaced     = 1'b0;
            m_data_next.best_improved    = load_impr;
            m_data_next.best_fitness_out = best_next;
        end else if (cmd.out_child) begin
            m_valid_next                 = 1'b1;
            m_data_next.nearest_slot     = SW'(32'(nearest_reg));
            m_data_next.was_replaced     = repl_reg;
            m_data_next.best_improved    = impr_reg;
            m_data_next.best_fitness_out = best_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.fit_cmp && child_impr) begin
            best_next = child_fit_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            dv3_reg     <= 1'b0;
            copy_v1_reg <= 1'b0;
            have_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            best_reg    <= cnr_pkg::BEST_RESET;
        end else begin
            s1_v_reg    <= cmd.srch_issue;
            s2_v_reg    <= s1_v_reg;
            dv3_reg     <= s2_v_reg && s2_end_reg;
            copy_v1_reg <= cmd.copy_issue;
            have_reg    <= have_next;
            m_valid_reg <= m_valid_next;
            best_reg    <= best_next;
        end
    end

    // payload state
    always_ff @(posedge aclk) begin
        s1_first_reg    <= cmd.srch_first;
        s1_end_reg      <= cmd.srch_end;
        s1_slot_reg     <= rd_slot;
        s2_first_reg    <= s1_first_reg;
        s2_end_reg      <= s1_end_reg;
        s2_slot_reg     <= s1_slot_reg;
        sq2_reg         <= $unsigned(prod);
        dist3_reg       <= acc_sum;
        slot3_reg       <= s2_slot_reg;
        copy_coord1_reg <= rd_coord;
        min_reg         <= min_next;
        nearest_reg     <= nearest_next;
        m_data_reg      <= m_data_next;
        if (s2_v_reg) begin
            acc_reg <= acc_sum;
        end
        if (is_child) begin
            child_fit_reg <= s_data.fitness_value;
        end
        if (cmd.fit_cmp) begin
            repl_reg <= fit_better;
            impr_reg <= child_impr;
        end
    end

    assign sts.pipe_busy  = s1_v_reg || s2_v_reg || dv3_reg;
    assign sts.fit_better = fit_better;
    assign sts.out_free   = out_free;
    assign m_valid        = m_valid_reg;
    assign m_data         = m_data_reg;

endmodule

>>> hdl/crowding_nearest_replace_unit.sv
// Top level of the deterministic crowding nearest-neighbor replacement unit.
//
// Load beats and non-final child beats are accepted back to back while idle; a final
// load beat waits for a free output register and returns its result in the next
// cycle. A final child beat starts a walk over every in-use slot and coordinate, one
// coordinate pair per cycle through the single read port of the population
// coordinate RAM, followed by pipeline drain and fitness lookup, and then a copy of
// the child into the table when it replaces the nearest slot. Ties in distance go
// to the lowest slot. No input beat is taken during the walk. The tables are not
// cleared by reset.
module crowding_nearest_replace_unit #(
    parameter int MAX_POPULATION = cnr_pkg::MAX_POPULATION_DEF,
    parameter int MAX_DIMENSION  = cnr_pkg::MAX_DIMENSION_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [cnr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cnr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  cnr_pkg::in_beat_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output cnr_pkg::out_beat_t              m_data
);

    localparam int PA = cnr_pkg::idx_bits(MAX_POPULATION);
    localparam int DA = cnr_pkg::idx_bits(MAX_DIMENSION);

    cnr_pkg::cmd_t cmd;
    cnr_pkg::sts_t sts;
    logic [PA-1:0] rd_slot;
    logic [DA-1:0] rd_coord;

    cnr_ctrl #(
        .MAX_POPULATION (MAX_POPULATION),
        .MAX_DIMENSION  (MAX_DIMENSION)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_kind    (s_data.kind),
        .s_last    (s_data.last_coord),
        .s_ready   (s_ready),
        .sts       (sts),
        .cmd       (cmd),
        .rd_slot   (rd_slot),
        .rd_coord  (rd_coord)
    );

    cnr_dpath #(
        .MAX_POPULATION (MAX_POPULATION),
        .MAX_DIMENSION  (MAX_DIMENSION)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_data   (s_data),
        .rd_slot  (rd_slot),
        .rd_coord (rd_coord),
        .sts      (sts),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

>>> hdl/cnr_checker.sv
// Port-level checker of the crowding replacement unit, bound to the top level.
`include "crowding_nearest_replace_unit_macros.svh"

module cnr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input cnr_pkg::in_beat_t               s_data,
    input logic                            m_valid,
    input logic                            m_ready,
    input cnr_pkg::out_beat_t              m_data
);

    logic in_beat;
    logic load_last;
    logic child_last;
    logic mid_beat;
    logic out_stall;

    assign in_beat    = s_valid && s_ready;
    assign load_last  = in_beat && s_data.last_coord && (s_data.kind == cnr_pkg::KIND_LOAD);
    assign child_last = in_beat && s_data.last_coord && (s_data.kind == cnr_pkg::KIND_CHILD);
    assign mid_beat   = in_beat && !s_data.last_coord && (!m_valid || m_ready);
    assign out_stall  = m_valid && !m_ready;

    // a final load beat is answered on the next cycle with its own slot
    `CNR_ASSERT_NEXT(a_load_result, aclk, aresetn, load_last, m_valid && !m_data.was_replaced && (m_data.nearest_slot == $past(s_data.slot)), "load result missing")
    // a final child beat starts the search and blocks new input
    `CNR_ASSERT_NEXT(a_child_busy, aclk, aresetn, child_last, !s_ready, "input open during search")
    // a beat that is not final never produces a result
    `CNR_ASSERT_NEXT(a_mid_quiet, aclk, aresetn, mid_beat, !m_valid, "result from a non-final beat")
    // a waiting result is held
    `CNR_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_valid && $stable(m_data), "stalled result changed")
    // reset empties the output register
    `CNR_ASSERT_AFTER_RESET(a_reset_out, aclk, aresetn, !m_valid, "result valid after reset")

endmodule

bind crowding_nearest_replace_unit cnr_checker u_cnr_checker (.*);

>>> test/crowding_nearest_replace_unit_tb.sv
// Self-checking testbench for the crowding nearest-replace unit, with a population mirror.
`timescale 1ns / 100ps

module crowding_nearest_replace_unit_tb;

    localparam int POP_SLOTS     = cnr_pkg::MAX_POPULATION_DEF;
    localparam int DIM_SLOTS     = cnr_pkg::MAX_DIMENSION_DEF;
    localparam int COORD_W       = cnr_pkg::COORD_BITS;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 32;
    localparam int DRAIN_CYCLES  = 200;
    localparam int HOLD_CYCLES   = 400;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // Mirror of the population table and best fitness; one outcome per final beat
    class population_mirror;
        logic signed [cnr_pkg::COORD_BITS-1:0] coords [POP_SLOTS][DIM_SLOTS];
        logic signed [cnr_pkg::FIT_W-1:0]      fitness [POP_SLOTS];
        logic signed [cnr_pkg::COORD_BITS-1:0] child [DIM_SLOTS];
        logic signed [cnr_pkg::FIT_W-1:0]      best;
        logic [cnr_pkg::POP_CFG_W-1:0]         pop_reg;
        logic [cnr_pkg::DIM_CFG_W-1:0]         dim_reg;
        cnr_pkg::out_beat_t                    awaited [$];
        int                                    mismatches;

        function new();
            best       = cnr_pkg::BEST_RESET;
            pop_reg    = cnr_pkg::POP_CFG_RESET;
            dim_reg    = cnr_pkg::DIM_CFG_RESET;
            mismatches = 0;
        endfunction

        // register values are clamped to the table sizes when used
        function int slots_searched();
            if (pop_reg < 1) return 1;
            if (pop_reg > POP_SLOTS) return POP_SLOTS;
            return int'(pop_reg);
        endfunction

        function int coords_used();
            if (dim_reg < 1) return 1;
            if (dim_reg > DIM_SLOTS) return DIM_SLOTS;
            return int'(dim_reg);
        endfunction

        function void write_register(input logic [cnr_pkg::CFG_INDEX_W-1:0] index,
                                     input logic [cnr_pkg::CFG_DATA_W-1:0] data);
            case (index)
                cnr_pkg::CFG_POPULATION_IN_USE: pop_reg = data[cnr_pkg::POP_CFG_W-1:0];
                cnr_pkg::CFG_DIMENSION_IN_USE:  dim_reg = data[cnr_pkg::DIM_CFG_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_beat(input cnr_pkg::in_beat_t b);
            logic signed [cnr_pkg::COORD_BITS-1:0] c;
            logic signed [cnr_pkg::FIT_W-1:0]      fit;
            cnr_pkg::out_beat_t                    res;
            int                                    p;
            int                                    d;
            int                                    near;
            longint                                sq_sum;
            longint                                min_dist;
            longint                                diff;
            c = b.coord_value;
            if (c > cnr_pkg::COORD_CEIL) c = cnr_pkg::COORD_CEIL;
            else if (c < cnr_pkg::COORD_FLOOR) c = cnr_pkg::COORD_FLOOR;
            fit = b.fitness_value;
            res = '0;
            res.nearest_slot = b.slot;
            if (b.kind == cnr_pkg::KIND_LOAD) begin
                coords[b.slot][b.coord_index] = c;
                if (!b.last_coord) return;
                fitness[b.slot] = fit;
                if (fit < best) begin
                    best = fit;
                    res.best_improved = 1'b1;
                end
            end else begin
                child[b.coord_index] = c;
                if (!b.last_coord) return;
                p = slots_searched();
                d = coords_used();
                near = 0;
                min_dist = 0;
                // exact squared distance; ties keep the lowest slot
                for (int i = 0; i < p; i++) begin
                    sq_sum = 0;
                    for (int j = 0; j < d; j++) begin
                        diff = longint'(child[j]) - longint'(coords[i][j]);
                        sq_sum += diff * diff;
                    end
                    if (i == 0 || sq_sum < min_dist) begin
                        min_dist = sq_sum;
                        near = i;
                    end
                end
                res.nearest_slot = near[cnr_pkg::SLOT_W-1:0];
                // strictly better child takes over the nearest slot
                if (fit < fitness[near]) begin
                    for (int j = 0; j < d; j++) coords[near][j] = child[j];
                    fitness[near] = fit;
                    res.was_replaced = 1'b1;
                    if (fit < best) begin
                        best = fit;
                        res.best_improved = 1'b1;
                    end
                end
            end
            res.best_fitness_out = best;
            awaited.push_back(res);
        endfunction

        function void check_outcome(input cnr_pkg::out_beat_t got);
            cnr_pkg::out_beat_t want;
            if (awaited.size() == 0) begin
                $error("result beat with nothing pending: nearest_slot %0d", got.nearest_slot);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (got.nearest_slot !== want.nearest_slot) begin
                $error("nearest_slot: expected %0d, actual %0d",
                       want.nearest_slot, got.nearest_slot);
                mismatches++;
            end
            if (got.was_replaced !== want.was_replaced) begin
                $error("was_replaced: expected %0d, actual %0d",
                       want.was_replaced, got.was_replaced);
                mismatches++;
            end
            if (got.best_improved !== want.best_improved) begin
                $error("best_improved: expected %0d, actual %0d",
                       want.best_improved, got.best_improved);
                mismatches++;
            end
            if (got.best_fitness_out !== want.best_fitness_out) begin
                $error("best_fitness_out: expected %0d, actual %0d",
                       want.best_fitness_out, got.best_fitness_out);
                mismatches++;
            end
        endfunction
    endclass

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [cnr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [cnr_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    cnr_pkg::in_beat_t               s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    cnr_pkg::out_beat_t              m_data;

    population_mirror mirror;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int hold_left   = 0;
    int cycle_count = 0;
    int sent_beats  = 0;
    int fit_trend   = 2000000;

    // which table entries hold data, so a search never reads an unwritten one
    bit coord_seen [POP_SLOTS][DIM_SLOTS];
    bit fit_seen [POP_SLOTS];

    crowding_nearest_replace_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("crowding_nearest_replace_unit regression: fail");
            $finish;
        end
    end

    // result side: check accepted beats, then pick next ready (long hold has priority)
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) mirror.check_outcome(m_data);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic cnr_pkg::in_beat_t make_beat(input logic kind,
                                           input logic [cnr_pkg::SLOT_W-1:0] slot,
                                           input logic [cnr_pkg::INDEX_W-1:0] idx,
                                           input logic signed [cnr_pkg::COORD_BITS-1:0] value,
                                           input logic signed [cnr_pkg::FIT_W-1:0] fit,
                                           input logic last);
        cnr_pkg::in_beat_t b;
        b.kind          = kind;
        b.slot          = slot;
        b.coord_index   = idx;
        b.coord_value   = value;
        b.fitness_value = fit;
        b.last_coord    = last;
        return b;
    endfunction

    // mostly in range, sometimes anything (saturation)
    function automatic logic signed [cnr_pkg::COORD_BITS-1:0] pick_coord();
        if ($urandom_range(9) == 0) return COORD_W'($urandom);
        return COORD_W'(int'($urandom_range(51200)) - 25600);
    endfunction

    // drifting downward so the best keeps improving now and then
    function automatic logic signed [cnr_pkg::FIT_W-1:0] pick_fitness();
        fit_trend -= int'($urandom_range(2000000));
        return fit_trend + int'($urandom_range(6000000)) - 3000000;
    endfunction

    function automatic int first_unloaded();
        for (int s = 0; s < mirror.slots_searched(); s++) begin
            if (!fit_seen[s]) return s;
            for (int j = 0; j < mirror.coords_used(); j++)
                if (!coord_seen[s][j]) return s;
        end
        return -1;
    endfunction

    // offer one beat after a random gap; hold it until accepted
    task automatic send_beat(input cnr_pkg::in_beat_t b);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        mirror.take_beat(b);
        if (b.kind == cnr_pkg::KIND_LOAD) begin
            coord_seen[b.slot][b.coord_index] = 1'b1;
            if (b.last_coord) fit_seen[b.slot] = 1'b1;
        end
        sent_beats++;
    endtask

    // wait for the block to go quiet, then write both registers
    task automatic write_registers(input logic [cnr_pkg::CFG_DATA_W-1:0] pop_data,
                                   input logic [cnr_pkg::CFG_DATA_W-1:0] dim_data);
        s_valid <= 1'b0;
        do @(posedge aclk); while (mirror.awaited.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= cnr_pkg::CFG_POPULATION_IN_USE;
        cfg_data  <= pop_data;
        @(posedge aclk);
        mirror.write_register(cnr_pkg::CFG_POPULATION_IN_USE, pop_data);
        cfg_index <= cnr_pkg::CFG_DIMENSION_IN_USE;
        cfg_data  <= dim_data;
        @(posedge aclk);
        mirror.write_register(cnr_pkg::CFG_DIMENSION_IN_USE, dim_data);
        cfg_we <= 1'b0;
    endtask

    // full vector for one slot, forward or reversed order
    task automatic send_load_vector(input int s);
        int d;
        int j;
        bit rev;
        bit last;
        d = mirror.coords_used();
        rev = ($urandom_range(3) == 0);
        for (int k = 0; k < d; k++) begin
            j = rev ? d - 1 - k : k;
            last = (k == d - 1);
            send_beat(make_beat(cnr_pkg::KIND_LOAD, s[cnr_pkg::SLOT_W-1:0],
                                j[cnr_pkg::INDEX_W-1:0], pick_coord(),
                                last ? pick_fitness() : $urandom, last));
        end
    endtask

    // child vector; an unfinished one may stop early and never sends a final beat
    task automatic send_child_vector(input bit finish);
        int d;
        int len;
        int j;
        int v;
        int base;
        bit rev;
        bit near_copy;
        bit last;
        d = mirror.coords_used();
        len = finish ? d : int'($urandom_range(1, d));
        base = $urandom_range(mirror.slots_searched() - 1);
        near_copy = finish && ($urandom_range(9) < 6);
        rev = ($urandom_range(3) == 0);
        for (int k = 0; k < len; k++) begin
            j = rev ? d - 1 - k : k;
            // close to an existing member most of the time
            if (near_copy) v = int'(mirror.coords[base][j]) + int'($urandom_range(600)) - 300;
            else v = pick_coord();
            last = finish && (k == d - 1);
            send_beat(make_beat(cnr_pkg::KIND_CHILD, 5'($urandom), j[cnr_pkg::INDEX_W-1:0],
                                v[cnr_pkg::COORD_BITS-1:0],
                                last ? pick_fitness() : $urandom, last));
        end
    endtask

    // any fields; a final beat here is only ever a load
    task automatic send_noise_beat();
        cnr_pkg::in_beat_t b;
        logic [63:0]       raw;
        raw = {$urandom, $urandom};
        b = raw[$bits(cnr_pkg::in_beat_t)-1:0];
        if (b.kind == cnr_pkg::KIND_CHILD || $urandom_range(4) != 0) b.last_coord = 1'b0;
        if (b.last_coord) b.fitness_value = pick_fitness();
        send_beat(b);
    endtask

    task automatic run_phase(input logic [cnr_pkg::CFG_DATA_W-1:0] pop_data,
                             input logic [cnr_pkg::CFG_DATA_W-1:0] dim_data,
                             input idle_mode_t mode, input int beats, input bit hold);
        int target;
        int pick;
        int s;
        write_registers(pop_data, dim_data);
        case (mode)
            IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin gap_pct = 65; stall_pct = 0;  end
            IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 65; end
            IDLE_BOTH:     begin gap_pct = 29; stall_pct = 29; end
            default:       begin gap_pct = 0;  stall_pct = 0;  end
        endcase
        if (hold) hold_left = HOLD_CYCLES;
        target = sent_beats + beats;
        while (sent_beats < target) begin
            pick = $urandom_range(99);
            s = first_unloaded();
            if (pick < 55) begin
                // children only once every searched slot is loaded
                if (s >= 0) send_load_vector(s);
                else send_child_vector(1'b1);
            end else if (pick < 75) begin
                send_load_vector($urandom_range(POP_SLOTS - 1));
            end else if (pick < 85) begin
                send_child_vector(1'b0);
            end else begin
                send_noise_beat();
            end
        end
    endtask

    initial begin
        mirror = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: saturation, ties, equal and worse children, slot out of use
        write_registers(7'd2, 7'd2);
        send_beat(make_beat(cnr_pkg::KIND_LOAD, 5'd0, 6'd0, 16'sh7FFF, 32'sh8000_0000, 1'b0));
        send_beat(make_beat(cnr_pkg::KIND_LOAD, 5'd0, 6'd1, 16'sh8000, 32'sh7FFF_FFFF, 1'b1));
        send_beat(make_beat(cnr_pkg::KIND_LOAD, 5'd1, 6'd0, -16'sd25601, 32'sd0, 1'b0));
        send_beat(make_beat(cnr_pkg::KIND_LOAD, 5'd1, 6'd1, 16'sd25601, 32'sd1000, 1'b1));
        send_beat(make_beat(cnr_pkg::KIND_CHILD, 5'd0, 6'd0, 16'sd0, 32'sd0, 1'b0));
        send_beat(make_beat(cnr_pkg::KIND_CHILD, 5'd0, 6'd1, 16'sd0, 32'sd2000, 1'b1));
        send_beat(make_beat(cnr_pkg::KIND_CHILD, 5'd0, 6'd1, 16'sd25600, 32'sd0, 1'b0));
        send_beat(make_beat(cnr_pkg::KIND_CHILD, 5'd0, 6'd0, -16'sd25600, 32'sd1000, 1'b1));
        send_beat(make_beat(cnr_pkg::KIND_CHILD, 5'd0, 6'd0, -16'sd25600, 32'sd999, 1'b1));
        send_beat(make_beat(cnr_pkg::KIND_LOAD, 5'd31, 6'd63, 16'sd25600, 32'sd0, 1'b0));
        send_beat(make_beat(cnr_pkg::KIND_LOAD, 5'd31, 6'd0, -16'sd1, 32'sd500, 1'b1));
        send_beat(make_beat(cnr_pkg::KIND_CHILD, 5'd0, 6'd0, -16'sd1, 32'sh7FFF_FFFF, 1'b1));
        send_beat(make_beat(cnr_pkg::KIND_CHILD, 5'd31, 6'd63, 16'sh7FFF, 32'sd0, 1'b0));

        // random phases; register values outside the range clamp to the table size
        run_phase(7'd4, 7'd3, IDLE_NONE, 70, 1'b0);
        run_phase(7'd63, 7'd1, IDLE_SENDER, 90, 1'b0);
        run_phase(7'd0, 7'd127, IDLE_RECEIVER, 200, 1'b0);
        run_phase(7'd8, 7'd8, IDLE_BOTH, 110, 1'b0);
        run_phase(7'd1, 7'd0, IDLE_NONE, 60, 1'b1);
        run_phase(7'd32, 7'd2, IDLE_BOTH, 90, 1'b0);
        run_phase(7'd2, 7'd5, IDLE_SENDER, 80, 1'b0);
        send_beat(make_beat(cnr_pkg::KIND_LOAD, 5'd31, 6'd63, 16'sh7FFF, 32'sh8000_0000, 1'b1));
        s_valid <= 1'b0;

        do @(posedge aclk); while (mirror.awaited.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mirror.mismatches == 0 && mirror.awaited.size() == 0) begin
            $display("crowding_nearest_replace_unit regression: pass");
        end else begin
            $display("crowding_nearest_replace_unit regression: fail");
        end
        $finish;
    end

endmodule
